/* src/brmc_pkg.sv */
// package: shared constants and types for the byte-wise rsa codec
`default_nettype none
package brmc_pkg;
    localparam int unsigned REG_W      = 62;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned DEF_WORD_BYTES = 8;
    localparam int unsigned ADDR_W     = 5;
    localparam logic [REG_W-1:0] RST_MODULUS = 62'd2;
    localparam logic [REG_W-1:0] RST_PUB_EXP = 62'd65537;
    localparam logic [REG_W-1:0] RST_PRV_EXP = 62'd1;
    localparam logic [ADDR_W-1:0] ADDR_MODULUS = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_PUB_EXP = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_PRV_EXP = 5'd16;
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // load base, exponent, modulus; start
        logic mul_start; // start a modular multiply
        logic mul_sel;   // 0: acc*base, 1: base*base
        logic exp_shift; // shift exponent right
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic mul_busy;
        logic exp_zero;
        logic exp_lsb;
    } dp_sts_t;
endpackage
`default_nettype wire

/* src/brmc_stream_if.sv */
// interface: valid/ready stream channels for request and result
`default_nettype none
interface brmc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    logic       end_of_message;
    modport source (output valid, req_type, data_byte, end_of_message, input ready);
    modport sink   (input valid, req_type, data_byte, end_of_message, output ready);
endinterface

interface brmc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface
`default_nettype wire

/* src/bytewise_rsa_modexp_codec_unit.sv */
// top level: byte-wise rsa codec with apb configuration
//  channel | dir | fields                               | handshake
//  req     | in  | req_type, data_byte, end_of_message  | valid/ready
//  rsp     | out | out_byte, last_of_run                | valid/ready
//  apb     | in  | modulus, public/private exponent     | psel/penable
// one request at a time: a load step, a bit-serial reduction of the base modulo n,
// then per exponent bit a decide step, an optional multiply and a square
// (each multiply an issue step plus add-and-double steps), then 1 or 8 result bytes
// reset sets the configuration registers to defaults; no clearing pass
// result stalls hold the output register; a new request is taken while the
// final result byte still waits
`default_nettype none
module bytewise_rsa_modexp_codec_unit
    import brmc_pkg::*;
#(
    parameter int unsigned WORD_BYTES = DEF_WORD_BYTES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    brmc_in_if.sink                req,
    brmc_out_if.source             rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);
    logic [REG_W-1:0]  modulus_reg, pub_reg, prv_reg;
    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [WORD_W-1:0] result, base;
    logic [REG_W-1:0]  exp_sel, mod_sel;

    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= RST_MODULUS;
            pub_reg     <= RST_PUB_EXP;
            prv_reg     <= RST_PRV_EXP;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                ADDR_MODULUS: modulus_reg <= pwdata[REG_W-1:0];
                ADDR_PUB_EXP: pub_reg     <= pwdata[REG_W-1:0];
                ADDR_PRV_EXP: prv_reg     <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr)
            ADDR_MODULUS: prdata = {2'b00, modulus_reg};
            ADDR_PUB_EXP: prdata = {2'b00, pub_reg};
            ADDR_PRV_EXP: prdata = {2'b00, prv_reg};
            default:      prdata = '0;
        endcase
    end

    brmc_control #(.WORD_BYTES(WORD_BYTES)) u_ctrl (
        .clk, .rst_n, .req, .rsp,
        .modulus(modulus_reg), .enc_exponent(pub_reg), .dec_exponent(prv_reg),
        .cmd, .sts, .result, .base, .exp_sel, .mod_sel
    );

    brmc_datapath u_dp (
        .clk, .rst_n, .cmd, .base_in(base), .exp_in(exp_sel), .mod_in(mod_sel),
        .sts, .result
    );
endmodule
`default_nettype wire

/* src/brmc_datapath.sv */
// datapath: modular exponentiation registers and add-and-double multiplier
`default_nettype none
module brmc_datapath
    import brmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    input  wire logic [WORD_W-1:0] base_in,
    input  wire logic [REG_W-1:0]  exp_in,
    input  wire logic [REG_W-1:0]  mod_in,
    output dp_sts_t                sts,
    output logic [WORD_W-1:0]      result
);
    logic [REG_W-1:0]  acc_reg, acc_next;
    logic [REG_W-1:0]  base_reg, base_next;
    logic [REG_W-1:0]  exp_reg, exp_next;
    logic [REG_W-1:0]  mod_reg;
    logic [REG_W:0]    ma_reg, ma_next;   // multiplicand, doubles
    logic [REG_W-1:0]  mb_reg, mb_next;   // multiplier, shifts
    logic [REG_W:0]    mp_reg, mp_next;   // partial product
    logic              msel_reg;
    logic              busy_reg, busy_next;
    logic              red_reg, red_next; // base reduction in progress
    logic [REG_W:0]    rb_reg, rb_next;   // running remainder of the base
    logic [WORD_W-1:0] bsh_reg, bsh_next; // base bits, msb first
    logic [5:0]        rcnt_reg, rcnt_next;
    logic [REG_W:0]    sum_a, dbl_a, rem_sh;

    assign sts.mul_busy = busy_reg | red_reg;
    assign sts.exp_zero = (exp_reg == '0);
    assign sts.exp_lsb  = exp_reg[0];
    assign result = (mod_reg < 62'd2) ? '0 : {{(WORD_W-REG_W){1'b0}}, acc_reg};

    // one add-and-double step per cycle; restoring remainder for the base
    always_comb
    begin
        acc_next = acc_reg; base_next = base_reg; exp_next = exp_reg;
        ma_next = ma_reg; mb_next = mb_reg; mp_next = mp_reg;
        busy_next = busy_reg; red_next = red_reg;
        rb_next = rb_reg; bsh_next = bsh_reg; rcnt_next = rcnt_reg;
        sum_a = mp_reg + ma_reg;
        if (sum_a >= {1'b0, mod_reg}) sum_a = sum_a - {1'b0, mod_reg};
        dbl_a = {ma_reg[REG_W-1:0], 1'b0};
        if (dbl_a >= {1'b0, mod_reg}) dbl_a = dbl_a - {1'b0, mod_reg};
        rem_sh = {rb_reg[REG_W-1:0], bsh_reg[WORD_W-1]};
        if (rem_sh >= {1'b0, mod_reg}) rem_sh = rem_sh - {1'b0, mod_reg};
        if (cmd.load)
        begin
            acc_next  = 62'd1;
            rb_next   = '0;
            bsh_next  = base_in;
            rcnt_next = 6'd0;
            red_next  = 1'b1;
            busy_next = 1'b0;
        end
        else if (red_reg)
        begin
            // bring in one base bit, subtract the modulus when not below
            rb_next   = rem_sh;
            bsh_next  = {bsh_reg[WORD_W-2:0], 1'b0};
            rcnt_next = rcnt_reg + 6'd1;
            if (rcnt_reg == 6'd63)
            begin
                red_next  = 1'b0;
                base_next = rem_sh[REG_W-1:0];
            end
        end
        else if (cmd.mul_start)
        begin
            ma_next   = {1'b0, base_reg};
            mb_next   = cmd.mul_sel ? base_reg : acc_reg;
            mp_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mb_reg[0]) mp_next = sum_a;
            ma_next = dbl_a;
            mb_next = mb_reg >> 1;
            if (mb_reg == '0)
            begin
                busy_next = 1'b0;
                if (msel_reg) base_next = mp_reg[REG_W-1:0];
                else          acc_next  = mp_reg[REG_W-1:0];
            end
        end
        // exponent loads with the base and shifts as each square starts
        if (cmd.load)
            exp_next = exp_in;
        else if (cmd.exp_shift)
            exp_next = exp_reg >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            red_reg  <= 1'b0;
            rcnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            red_reg  <= red_next;
            rcnt_reg <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next; base_reg <= base_next; exp_reg <= exp_next;
        ma_reg <= ma_next; mb_reg <= mb_next; mp_reg <= mp_next;
        rb_reg <= rb_next; bsh_reg <= bsh_next;
        if (cmd.load) mod_reg <= mod_in;
        if (cmd.mul_start && !red_reg && !cmd.load) msel_reg <= cmd.mul_sel;
    end

    // multiplier never starts while busy; reduction ends once its bit counter reaches its last value
    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) (cmd.mul_start && busy_reg) |-> 1'b0;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("mul start while busy");
    a_red_len: assert property (@(posedge clk) disable iff (!rst_n)
        (red_reg && rcnt_reg == 6'd63) |=> !red_reg) else $error("reduction overrun");
    a_mp_below: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && mod_reg >= 62'd2) |-> (mp_reg < {1'b0, mod_reg}))
        else $error("partial product not reduced");
endmodule
`default_nettype wire

/* src/brmc_control.sv */
// controller: request sequencing, square-and-multiply control, byte output
`default_nettype none
module brmc_control
    import brmc_pkg::*;
#(
    parameter int unsigned WORD_BYTES = DEF_WORD_BYTES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    brmc_in_if.sink                req,
    brmc_out_if.source             rsp,
    input  wire logic [REG_W-1:0]  modulus,
    input  wire logic [REG_W-1:0]  enc_exponent,
    input  wire logic [REG_W-1:0]  dec_exponent,
    output dp_cmd_t                cmd,
    input  wire dp_sts_t           sts,
    input  wire logic [WORD_W-1:0] result,
    output logic [WORD_W-1:0]      base,
    output logic [REG_W-1:0]       exp_sel,
    output logic [REG_W-1:0]       mod_sel
);
    typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_MUL, S_SQR, S_OUT} state_t;
    localparam int unsigned CNT_W = 3;
    state_t            state_reg;
    logic [WORD_W-1:0] word_reg;
    logic [CNT_W-1:0]  gath_reg;
    logic              dec_reg;
    logic [WORD_W-1:0] res_reg;
    logic [CNT_W-1:0]  ocnt_reg;
    logic              ovalid_reg;
    logic              olast_reg;
    logic [7:0]        obyte_reg;
    logic              take;
    logic [CNT_W:0]    pos;
    logic              pending;

    assign req.ready       = (state_reg == S_IDLE);
    assign take            = req.valid && req.ready;
    assign rsp.valid       = ovalid_reg;
    assign rsp.out_byte    = obyte_reg;
    assign rsp.last_of_run = olast_reg;
    assign pos = {1'b0, gath_reg} + 1'b1;
    assign pending = sts.mul_busy;
    assign exp_sel = dec_reg ? dec_exponent : enc_exponent;
    assign mod_sel = modulus;
    assign base    = word_reg;

    // datapath commands; each square also shifts the exponent
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_START: cmd.load = 1'b1;
            S_MUL:
            begin
                cmd.mul_start = !pending;
                cmd.mul_sel   = 1'b0;
            end
            S_SQR:
            begin
                cmd.mul_start = !pending;
                cmd.mul_sel   = 1'b1;
                cmd.exp_shift = !pending;
            end
            default: cmd = '0;
        endcase
    end

    // sequencing: gather bytes, load, then per bit wait idle, optional multiply, square and shift, then output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            word_reg   <= '0;
            gath_reg   <= '0;
            dec_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
            obyte_reg  <= '0;
            ocnt_reg   <= '0;
            res_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        if (req.req_type == REQ_ENCRYPT)
                        begin
                            word_reg  <= {{(WORD_W-8){1'b0}}, req.data_byte};
                            gath_reg  <= '0;
                            dec_reg   <= 1'b0;
                            state_reg <= S_START;
                        end
                        else
                        begin
                            word_reg <= word_reg
                                | ({{(WORD_W-8){1'b0}}, req.data_byte} << {gath_reg, 3'b000});
                            dec_reg  <= 1'b1;
                            if (pos >= WORD_BYTES[CNT_W:0] || req.end_of_message)
                            begin
                                gath_reg  <= '0;
                                state_reg <= S_START;
                            end
                            else
                                gath_reg <= pos[CNT_W-1:0];
                        end
                    end
                end
                S_START:
                    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!pending)
                    begin
                        if (sts.exp_zero)
                        begin
                            res_reg   <= result;
                            word_reg  <= '0;
                            ocnt_reg  <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= sts.exp_lsb ? S_MUL : S_SQR;
                    end
                end
                S_MUL:
                    if (!pending) state_reg <= S_SQR;
                S_SQR:
                    if (!pending) state_reg <= S_WAIT;
                S_OUT:
                begin
                    if (!ovalid_reg || rsp.ready)
                    begin
                        ovalid_reg <= 1'b1;
                        obyte_reg  <= res_reg[8*ocnt_reg +: 8];
                        if (dec_reg || ocnt_reg == CNT_W'(WORD_BYTES - 1))
                        begin
                            olast_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                            olast_reg <= 1'b0;
                        ocnt_reg <= ocnt_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (ovalid_reg && rsp.ready && !(state_reg == S_OUT))
                ovalid_reg <= 1'b0;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg != S_OUT) else $error("output without work");
    a_gath: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) |-> gath_reg == '0) else $error("gather count not cleared");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.last_of_run && rsp.ready) |=> !(state_reg == S_OUT && dec_reg))
        else $error("extra decrypt byte");
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// testbench: byte-wise rsa codec, random and directed requests checked against a local predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top
    import brmc_pkg::*;
();

    typedef struct {
        logic [7:0] out_byte;
        logic       last_of_run;
    } rsa_byte_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    wire logic [63:0] prdata;
    wire logic pready;

    brmc_in_if  in_ch();
    brmc_out_if out_ch();

    bytewise_rsa_modexp_codec_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (in_ch),
        .rsp     (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and register shadow
    logic [REG_W-1:0] key_modulus;
    logic [REG_W-1:0] key_pub_exp;
    logic [REG_W-1:0] key_prv_exp;
    logic [63:0]      gather_word;
    int unsigned      gather_count;
    rsa_byte_t        expected_bytes[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned requests_sent;
    int unsigned bytes_checked;
    int unsigned words_decrypted;
    int unsigned config_writes;
    int unsigned errors;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // exact modular exponentiation with wide intermediates
    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [REG_W-1:0] ex,
                                            logic [REG_W-1:0] n);
        logic [127:0] acc;
        logic [127:0] b;
        logic [127:0] nn;
        if (n < 2)
            return 64'd0;
        nn  = 128'(n);
        b   = 128'(base) % nn;
        acc = 128'd1;
        while (ex != 0)
        begin
            if (ex[0])
                acc = (acc * b) % nn;
            b  = (b * b) % nn;
            ex = ex >> 1;
        end
        return acc[63:0];
    endfunction

    // work out the result bytes of one accepted request
    task automatic predict_request(logic kind, logic [7:0] data, logic eom);
        logic [63:0] value;
        rsa_byte_t   rb;
        if (kind == REQ_ENCRYPT)
        begin
            gather_word  = 64'd0;
            gather_count = 0;
            value = mod_pow(64'(data), key_pub_exp, key_modulus);
            for (int k = 0; k < DEF_WORD_BYTES; k++)
            begin
                rb.out_byte    = value[8*k +: 8];
                rb.last_of_run = (k == DEF_WORD_BYTES - 1);
                expected_bytes = {expected_bytes, rb};
            end
        end
        else
        begin
            gather_word[8*gather_count +: 8] = data;
            gather_count++;
            if (gather_count >= DEF_WORD_BYTES || eom)
            begin
                value = mod_pow(gather_word, key_prv_exp, key_modulus);
                gather_word  = 64'd0;
                gather_count = 0;
                rb.out_byte    = value[7:0];
                rb.last_of_run = 1'b1;
                expected_bytes = {expected_bytes, rb};
                words_decrypted++;
            end
        end
    endtask

    // send one request and wait for it to be taken
    task automatic send_request(logic kind, logic [7:0] data, logic eom);
        in_ch.valid          <= 1'b1;
        in_ch.req_type       <= kind;
        in_ch.data_byte      <= data;
        in_ch.end_of_message <= eom;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_request(kind, data, eom);
        requests_sent++;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // wait until every expected byte has come, then let the block settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // apb register write, setup then access, then read back
    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready !== 1'b1)
        begin
            errors++;
            if (errors <= 10)
                $display("pready low in access cycle at address %0d", addr);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODULUS)
            key_modulus = value[REG_W-1:0];
        else if (addr == ADDR_PUB_EXP)
            key_pub_exp = value[REG_W-1:0];
        else if (addr == ADDR_PRV_EXP)
            key_prv_exp = value[REG_W-1:0];
        config_writes++;
        @(posedge clk);
        if (prdata !== {2'b00, value[REG_W-1:0]})
        begin
            errors++;
            if (errors <= 10)
                $display("read back at address %0d: expected %016h, got %016h",
                         addr, {2'b00, value[REG_W-1:0]}, prdata);
        end
    endtask

    task automatic set_keys(logic [63:0] n, logic [63:0] e, logic [63:0] d);
        reg_write(ADDR_MODULUS, n);
        reg_write(ADDR_PUB_EXP, e);
        reg_write(ADDR_PRV_EXP, d);
    endtask

    // random value with exactly the given bit length
    function automatic logic [63:0] rand_bits(int unsigned bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v = v & ((64'd1 << bits) - 1);
        v[bits-1] = 1'b1;
        return v;
    endfunction

    // exponents kept short mostly, as each bit costs a long square and possibly a long multiply
    function automatic logic [63:0] rand_exponent();
        if ($urandom_range(0, 19) == 0)
            return rand_bits(REG_W);
        return rand_bits($urandom_range(1, 12));
    endfunction

    // result checker
    always @(posedge clk)
    begin
        rsa_byte_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result byte %02h last %0b",
                             out_ch.out_byte, out_ch.last_of_run);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (want.out_byte !== out_ch.out_byte
                    || want.last_of_run !== out_ch.last_of_run)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected byte %02h last %0b, got %02h last %0b",
                                 want.out_byte, want.last_of_run,
                                 out_ch.out_byte, out_ch.last_of_run);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // reset values of the registers, modulus two
    task automatic test_reset_defaults();
        send_request(REQ_ENCRYPT, 8'd3, 1'b0);
        send_request(REQ_DECRYPT, 8'd5, 1'b1);
        send_request(REQ_DECRYPT, 8'd4, 1'b1);
        wait_drained();
    endtask

    // field extremes, short and full words, discard and the odd keys
    task automatic test_directed();
        set_keys(64'h3FFF_FFFF_FFFF_FFFF, 64'd3, 64'd5);
        send_request(REQ_ENCRYPT, 8'h00, 1'b0);
        send_request(REQ_ENCRYPT, 8'hFF, 1'b1);
        send_request(REQ_ENCRYPT, 8'h01, 1'b0);
        for (int k = 0; k < 8; k++)
            send_request(REQ_DECRYPT, 8'hFF, 1'b0);
        send_request(REQ_DECRYPT, 8'hA5, 1'b0);
        send_request(REQ_DECRYPT, 8'h5A, 1'b1);
        send_request(REQ_DECRYPT, 8'h00, 1'b1);
        send_request(REQ_DECRYPT, 8'h77, 1'b0);
        send_request(REQ_DECRYPT, 8'h88, 1'b0);
        send_request(REQ_ENCRYPT, 8'h80, 1'b0);
        send_request(REQ_DECRYPT, 8'h12, 1'b1);
        wait_drained();
        // widest exponents
        set_keys(64'd3_000_000_019, 64'h3FFF_FFFF_FFFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFF);
        send_request(REQ_ENCRYPT, 8'hC3, 1'b0);
        send_request(REQ_DECRYPT, 8'h3C, 1'b1);
        wait_drained();
        // degenerate modulus, then zero exponents
        set_keys(64'd1, 64'd7, 64'd7);
        send_request(REQ_ENCRYPT, 8'h42, 1'b0);
        send_request(REQ_DECRYPT, 8'h42, 1'b1);
        wait_drained();
        set_keys(64'd0, 64'd0, 64'd0);
        send_request(REQ_ENCRYPT, 8'h42, 1'b0);
        wait_drained();
        set_keys(64'd2, 64'd0, 64'd0);
        send_request(REQ_ENCRYPT, 8'h42, 1'b0);
        send_request(REQ_DECRYPT, 8'h42, 1'b1);
        wait_drained();
    endtask

    // mostly decrypt words of random length, with encrypt bytes between
    task automatic test_random(int unsigned count, int unsigned idle_pct,
                               int unsigned stall_pct, bit pause_midway);
        int unsigned sent;
        int unsigned len;
        logic        eom;
        sent = 0;
        set_keys(rand_bits($urandom_range(2, REG_W)), rand_exponent(), rand_exponent());
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < count)
        begin
            if (pause_midway && sent >= count / 2)
            begin
                pause_midway = 1'b0;
                wait_drained();
            end
            if ($urandom_range(0, 99) < 30)
            begin
                send_request(REQ_ENCRYPT, 8'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                begin
                    eom = (k == len - 1) ? (len < 8 || $urandom_range(0, 1))
                                         : ($urandom_range(0, 19) == 0);
                    send_request(REQ_DECRYPT, 8'($urandom), eom);
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_ENCRYPT;
        in_ch.data_byte      = 8'd0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready   = 1'b0;
        key_modulus    = RST_MODULUS;
        key_pub_exp    = RST_PUB_EXP;
        key_prv_exp    = RST_PRV_EXP;
        gather_word    = 64'd0;
        gather_count   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        requests_sent  = 0;
        bytes_checked  = 0;
        words_decrypted = 0;
        config_writes  = 0;
        errors         = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_random(100, 0, 0, 1'b1);
        test_random(100, 50, 0, 1'b0);
        test_random(100, 0, 50, 1'b0);
        test_random(100, 14, 14, 1'b0);

        wait_drained();
        if (expected_bytes.size() != 0)
            errors++;
        $display("covered %0d requests, %0d result bytes, %0d decrypted words, %0d key writes",
                 requests_sent, bytes_checked, words_decrypted, config_writes);
        $display("keys spanned degenerate, zero-exponent, full-width and random short ones");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #250_000_000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
